FILE: rtl/itd_pkg.sv
// itd_pkg: shared constants, types and helper functions for the radix converter
// no dependencies; imported by every module of the converter except itd_ram
`timescale 1ns / 1ps

package itd_pkg;

  // default sizes handed to the top-level parameters
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int MAX_DIGITS_HI  = 64;

  // digit count field of a queued job, wide enough for any digit limit up to MAX_DIGITS_HI
  localparam int CNT_W = $clog2(MAX_DIGITS_HI + 1);

  // quotient bits retired per divider cycle
  localparam int DIV_STEPS = 8;

  // jobs in flight between divider and digit emitter
  localparam int QUEUE_DEPTH = 2;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  // register word index decoded from paddr
  localparam logic REG_RADIX = 1'b0;

  // first digit value that prints as a letter
  localparam logic [DIGIT_W-1:0] LETTER_DIGIT_MIN = 4'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO       = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A          = 7'h41;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < LETTER_DIGIT_MIN) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - LETTER_DIGIT_MIN);
    end
    return c;
  endfunction

endpackage

FILE: rtl/itd_ram.sv
// itd_ram: generic simple dual-port ram, one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps

module itd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/itd_queue.sv
// itd_queue: small fifo of conversion jobs between divider and emitter
// depends on itd_pkg (job_t)
`timescale 1ns / 1ps

module itd_queue import itd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

endmodule

FILE: rtl/itd_front.sv
// itd_front: accepts values and divides them down, storing remainders per bank
// depends on itd_pkg (job_t, rel_t, eff_radix)
`timescale 1ns / 1ps

module itd_front import itd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [VALUE_BITS-1:0]           in_value,
  input  logic [RADIX_W-1:0]              radix_cfg,
  output logic                            busy,
  output logic                            ram_we,
  output logic [$clog2(MAX_DIGITS):0]     ram_waddr,
  output logic [DIGIT_W-1:0]              ram_wdata,
  output logic                            push,
  output job_t                            push_job,
  input  rel_t                            rel
);

  localparam int BL_W   = $clog2(VALUE_BITS + 1);
  localparam int STEPS  = (DIV_STEPS < VALUE_BITS) ? DIV_STEPS : VALUE_BITS;
  localparam int CW     = $clog2(MAX_DIGITS + 1);
  localparam int DIG_AW = $clog2(MAX_DIGITS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                  state_r, state_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [BL_W-1:0]       bl_r, bl_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [RADIX_W-1:0]    rad_r, rad_nxt;
  logic                  bank_r, bank_nxt;
  logic [1:0]            bank_busy_r, bank_busy_nxt;

  logic [VALUE_BITS-1:0] q;
  logic [DIGIT_W-1:0]    r;
  logic [DIGIT_W:0]      t;
  logic                  last;
  logic                  accept;
  logic                  done;

  // restoring division, a few quotient bits per cycle, msb first
  always_comb begin
    q = quo_r;
    r = rem_r;
    t = '0;
    for (int i = 0; i < STEPS; i++) begin
      if (BL_W'(i) < bl_r) begin
        t = {r, q[VALUE_BITS-1]};
        q = {q[VALUE_BITS-2:0], 1'b0};
        if (t >= rad_r) begin
          t    = t - rad_r;
          q[0] = 1'b1;
        end
        r = t[DIGIT_W-1:0];
      end
    end
  end

  assign last   = (bl_r <= BL_W'(STEPS));
  assign done   = (q == '0) || (cnt_r == CW'(MAX_DIGITS - 1));
  assign accept = (state_r == ST_IDLE) && !bank_busy_r[bank_r] && start;
  assign busy   = (state_r == ST_DIV) || bank_busy_r[bank_r];

  assign ram_we    = (state_r == ST_DIV) && last;
  assign ram_waddr = {bank_r, cnt_r[DIG_AW-1:0]};
  assign ram_wdata = r;
  assign push      = ram_we && done;

  always_comb begin
    push_job.bank  = bank_r;
    push_job.count = CNT_W'(cnt_r) + CNT_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bl_nxt        = bl_r;
    cnt_nxt       = cnt_r;
    rad_nxt       = rad_r;
    bank_nxt      = bank_r;
    bank_busy_nxt = bank_busy_r;
    if (rel.valid) begin
      bank_busy_nxt[rel.bank] = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          quo_nxt   = in_value;
          rem_nxt   = '0;
          bl_nxt    = BL_W'(VALUE_BITS);
          cnt_nxt   = '0;
          rad_nxt   = eff_radix(radix_cfg);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = q;
        rem_nxt = r;
        bl_nxt  = bl_r - BL_W'(STEPS);
        if (last) begin
          rem_nxt = '0;
          bl_nxt  = BL_W'(VALUE_BITS);
          if (done) begin
            bank_busy_nxt[bank_r] = 1'b1;
            bank_nxt              = !bank_r;
            state_nxt             = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      bank_busy_r <= '0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      bank_busy_r <= bank_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    bl_r  <= bl_nxt;
    cnt_r <= cnt_nxt;
    rad_r <= rad_nxt;
  end

endmodule

FILE: rtl/itd_back.sv
// itd_back: takes queued jobs and emits stored remainders as ascii digits, msd first
// depends on itd_pkg (job_t, rel_t, to_ascii)
`timescale 1ns / 1ps

module itd_back import itd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  job_t                        q_head,
  output logic                        pop,
  output rel_t                        rel,
  output logic                        ram_re,
  output logic [$clog2(MAX_DIGITS):0] ram_raddr,
  input  logic [DIGIT_W-1:0]          ram_rdata,
  output logic                        out_valid,
  output logic [CHAR_W-1:0]           out_digit_char,
  output logic                        out_last_digit
);

  localparam int DIG_AW = $clog2(MAX_DIGITS);

  logic              active_r;
  logic              bank_r;
  logic [DIG_AW-1:0] idx_r;
  logic              rd_v_r;
  logic              rd_last_r;
  logic              final_rd;

  // next job is taken in the cycle of the last read of the current one
  assign final_rd  = active_r && (idx_r == '0);
  assign pop       = !q_empty && (!active_r || final_rd);
  assign rel.valid = final_rd;
  assign rel.bank  = bank_r;
  assign ram_re    = active_r;
  assign ram_raddr = {bank_r, idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      rd_v_r   <= 1'b0;
    end else begin
      rd_v_r <= active_r;
      if (pop) begin
        active_r <= 1'b1;
      end else if (final_rd) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r <= (idx_r == '0);
    if (pop) begin
      bank_r <= q_head.bank;
      idx_r  <= DIG_AW'(q_head.count - CNT_W'(1));
    end else if (active_r) begin
      idx_r <= idx_r - DIG_AW'(1);
    end
  end

  assign out_valid      = rd_v_r;
  assign out_last_digit = rd_last_r;
  assign out_digit_char = to_ascii(ram_rdata);

endmodule

FILE: rtl/integer_to_radix_digits.sv
// integer_to_radix_digits: top level of the unsigned integer to radix 2..16 converter
// depends on itd_pkg, itd_ram, itd_queue, itd_front, itd_back
`timescale 1ns / 1ps

// channel   ports                                          transaction when
// input     start, busy, in_value                          start high, busy low
// result    out_valid, out_digit_char, out_last_digit      out_valid high, one cycle each
// config    psel, penable, pwrite, paddr, pwdata, prdata   psel, penable, pwrite, pready high
//
// the divider retires 8 quotient bits a cycle; each digit takes a full pass over the
// VALUE_BITS-bit quotient
// the emitter reads the remainder ram one digit a cycle; a queued job passes the queue
// count, the emitter's index register and the registered ram read before its first
// digit shows, and the rest follow back to back
// two remainder banks let the next value divide while the previous one is emitted
// synchronous active-low reset clears control only; remainder ram needs no clearing
// the receiver cannot stall, so the only backpressure is busy on the input side

module integer_to_radix_digits import itd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  // result channel
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready
);

  // two banks of MAX_DIGITS remainder slots, bank select is the address msb
  localparam int RAM_AW    = $clog2(MAX_DIGITS) + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  logic [RADIX_W-1:0] radix_r;
  logic               cfg_wr;

  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr;
  logic [DIGIT_W-1:0] ram_wdata;
  logic               ram_re;
  logic [RAM_AW-1:0]  ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  logic               push;
  job_t               push_job;
  logic               pop;
  logic               q_empty;
  job_t               q_head;
  rel_t               rel;

  // radix register, word 0; the other word is unused and ignores writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr && (paddr[PADDR_W-1] == REG_RADIX)) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_RADIX) ? APB_W'(radix_r) : '0;

  // front: takes a value, latches the saturated radix and divides it into a bank
  itd_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_value  (in_value),
    .radix_cfg (radix_r),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_job  (push_job),
    .rel       (rel)
  );

  // remainder store shared by both banks
  itd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // finished jobs (bank and digit count) waiting for the emitter
  itd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: walks a bank from the top digit down, frees the bank after its last read
  itd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .pop            (pop),
    .rel            (rel),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule
